// ===== hdl/load_cell_stability_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Load cell stability detector assertion macros
// Shared check forms for the detector's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_STABILITY_DETECTOR_MACROS_SVH
`define LOAD_CELL_STABILITY_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Load cell stability detector package
// Shared widths, register indexes, reset values and helper functions.
// ----------------------------------------------------------------------------
package lcsd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int THR_W = 23;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int WINDOW_DEFAULT = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [THR_W-1:0] thr_t;
  typedef logic [DIFF_W-1:0] mag_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DEADBAND = 2'd0;
  localparam cfg_idx_t REG_STABILITY = 2'd1;
  localparam cfg_idx_t REG_CHANGE = 2'd2;

  localparam thr_t DEADBAND_RESET = 23'd10;
  localparam thr_t STABILITY_RESET = 23'd20;
  localparam thr_t CHANGE_RESET = 23'd50;

  function automatic mag_t absdiff(input sample_t a, input sample_t b);
    logic signed [DIFF_W-1:0] d;
    d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    return mag_t'(d[DIFF_W-1] ? -d : d);
  endfunction

endpackage

// ===== hdl/lcsd_cell.sv =====
// ----------------------------------------------------------------------------
// Load cell stability detector window cell
// Holds one window reading, shifts in from its neighbor or the input, and checks the step.
// ----------------------------------------------------------------------------
module lcsd_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  lcsd_pkg::sample_t din,
  input  lcsd_pkg::sample_t cmp_in,
  input  lcsd_pkg::thr_t    thr,
  input  logic             ok_in,
  output lcsd_pkg::sample_t q,
  output logic             ok_out
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= din;
    end
  end

  assign ok_out = ok_in &&
                  (lcsd_pkg::absdiff(q, cmp_in) <= lcsd_pkg::mag_t'(thr));

endmodule

// ===== hdl/load_cell_stability_detector.sv =====
// ----------------------------------------------------------------------------
// Load cell stability detector
// Deadbands weight readings, keeps a window of recent readings in a row of
// cells, flags a stable weight and decides when it should be reported.
// ----------------------------------------------------------------------------
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    sensor_ready, weight_sample
//   out      out_valid / out_ready  stable, stable_weight, report
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is held in the evaluation stage after its transfer and in_ready
// stays low until it advances, so no new item is taken while one is pending.
// The evaluation stage is freed once the neighbor compare across the cell row
// has been registered into the output register.
// Reset is synchronous; the window contents have no reset and are only read
// once the fill count shows the window full. Configuration is always ready.
module load_cell_stability_detector #(
  parameter int WINDOW = lcsd_pkg::WINDOW_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     sensor_ready,
  input  lcsd_pkg::sample_t        weight_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     stable,
  output lcsd_pkg::sample_t        stable_weight,
  output logic                     report,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  lcsd_pkg::cfg_idx_t       cfg_index,
  input  lcsd_pkg::thr_t           cfg_data
);

  localparam int CNT_W = $clog2(WINDOW + 2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WINDOW + 1);

  lcsd_pkg::thr_t deadband_threshold;
  lcsd_pkg::thr_t step_limit;
  lcsd_pkg::thr_t change_threshold;

  logic [CNT_W-1:0]  count;
  lcsd_pkg::sample_t last_reported;
  logic              pending;
  logic              pending_taken;

  logic              in_xfer;
  logic              shift_en;
  logic              advance;
  lcsd_pkg::sample_t sample_db;
  lcsd_pkg::sample_t win [WINDOW];
  lcsd_pkg::sample_t cell_din [WINDOW];
  lcsd_pkg::sample_t cell_cmp [WINDOW];
  logic              ok_chain [WINDOW+1];

  lcsd_pkg::sample_t w;
  logic              full;
  logic              stable_next;
  logic              report_next;

  assign cfg_ready = 1'b1;
  assign in_ready = !pending;
  assign in_xfer = in_valid && in_ready;
  assign shift_en = in_xfer && sensor_ready;
  assign advance = pending && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_threshold <= lcsd_pkg::DEADBAND_RESET;
      step_limit <= lcsd_pkg::STABILITY_RESET;
      change_threshold <= lcsd_pkg::CHANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcsd_pkg::REG_DEADBAND:  deadband_threshold <= cfg_data;
        lcsd_pkg::REG_STABILITY: step_limit <= cfg_data;
        lcsd_pkg::REG_CHANGE:    change_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample_db = (lcsd_pkg::absdiff(weight_sample, '0) <
                      lcsd_pkg::mag_t'(deadband_threshold)) ? '0 : weight_sample;

  assign ok_chain[0] = 1'b1;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_din[i] = sample_db;
      assign cell_cmp[i] = win[i];
    end else begin : g_body
      assign cell_din[i] = win[i-1];
      assign cell_cmp[i] = win[i-1];
    end
    lcsd_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (cell_din[i]),
      .cmp_in   (cell_cmp[i]),
      .thr      (step_limit),
      .ok_in    (ok_chain[i]),
      .q        (win[i]),
      .ok_out   (ok_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pending <= 1'b0;
      pending_taken <= 1'b0;
    end else begin
      if (shift_en && (count < CNT_MAX)) begin
        count <= count + CNT_W'(1);
      end
      if (in_xfer) begin
        pending <= 1'b1;
        pending_taken <= sensor_ready;
      end else if (advance) begin
        pending <= 1'b0;
      end
    end
  end

  assign w = win[0];
  assign full = pending_taken && (count >= CNT_FULL);
  assign stable_next = full && ok_chain[WINDOW];
  assign report_next = stable_next && !w[lcsd_pkg::SAMPLE_W-1] &&
                       ((lcsd_pkg::absdiff(w, last_reported) >=
                         lcsd_pkg::mag_t'(change_threshold)) ||
                        (count == CNT_FULL));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_reported <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (report_next) begin
          last_reported <= w;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stable <= stable_next;
      stable_weight <= stable_next ? w : '0;
      report <= report_next;
    end
  end

  `include "load_cell_stability_detector_macros.svh"

  `LCSD_ASSERT_NOW(a_report_needs_stable, clk, rst, out_valid && report, stable, "Report without a stable weight.")
  `LCSD_ASSERT_NOW(a_unstable_zero, clk, rst, out_valid && !stable, stable_weight == '0, "Unstable result carries a nonzero weight.")
  `LCSD_ASSERT_NOW(a_report_nonneg, clk, rst, out_valid && report, !stable_weight[lcsd_pkg::SAMPLE_W-1], "Negative weight reported.")
  `LCSD_ASSERT_NEXT(a_accept_pending, clk, rst, in_valid && in_ready, pending && !in_ready, "Transfer did not enter the evaluation stage.")
  `LCSD_ASSERT_NEXT(a_advance_output, clk, rst, advance, out_valid && !pending, "Evaluated item did not reach the output register.")

endmodule

// ===== tb/load_cell_stability_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Load cell stability detector testbench
// Streams weight readings through the detector under random idling and
// stalls, predicts each readout from its own copy of the window, count, last
// reported weight and thresholds, and compares every readout field by field.
// ----------------------------------------------------------------------------
module load_cell_stability_detector_test;

  localparam int WIN = lcsd_pkg::WINDOW_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN = 10;
  localparam int IDLE_PCT = 12;
  localparam lcsd_pkg::cfg_idx_t REG_UNUSED = 2'd3;
  localparam lcsd_pkg::thr_t THR_MAX = '1;
  localparam int W_MAX = 8388607;
  localparam int W_MIN = -8388608;

  typedef struct {
    logic              is_stable;
    lcsd_pkg::sample_t weight;
    logic              send;
  } readout_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               sensor_ready = 1'b0;
  lcsd_pkg::sample_t  weight_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               stable;
  lcsd_pkg::sample_t  stable_weight;
  logic               report;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  lcsd_pkg::cfg_idx_t cfg_index = '0;
  lcsd_pkg::thr_t     cfg_data = '0;

  readout_t expected_readouts[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  bit       steady_mode = 1'b0;

  lcsd_pkg::thr_t deadband_limit = lcsd_pkg::DEADBAND_RESET;
  lcsd_pkg::thr_t stability_limit = lcsd_pkg::STABILITY_RESET;
  lcsd_pkg::thr_t change_limit = lcsd_pkg::CHANGE_RESET;
  int       recent_readings[WIN];
  int       readings_taken = 0;
  int       last_sent_weight = 0;

  load_cell_stability_detector #(.WINDOW(WIN)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sensor_ready(sensor_ready),
    .weight_sample(weight_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stable(stable),
    .stable_weight(stable_weight),
    .report(report),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_weight(input int v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  function automatic void predict_readout(input logic rdy, input lcsd_pkg::sample_t raw);
    readout_t r;
    int w;
    bit steady;
    r = '{is_stable: 1'b0, weight: '0, send: 1'b0};
    if (rdy) begin
      w = int'(raw);
      if (magnitude(w) < int'(deadband_limit)) w = 0;
      for (int i = WIN - 1; i > 0; i--) recent_readings[i] = recent_readings[i - 1];
      recent_readings[0] = w;
      if (readings_taken < WIN + 1) readings_taken++;
      if (readings_taken >= WIN) begin
        steady = 1'b1;
        for (int i = 1; i < WIN; i++) begin
          if (magnitude(recent_readings[i] - recent_readings[i - 1]) > int'(stability_limit))
            steady = 1'b0;
        end
        if (steady) begin
          r.is_stable = 1'b1;
          r.weight = lcsd_pkg::sample_t'(w);
          if (w >= 0 && (magnitude(w - last_sent_weight) >= int'(change_limit) ||
                         readings_taken == WIN)) begin
            r.send = 1'b1;
            last_sent_weight = w;
          end
        end
      end
    end
    expected_readouts.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_readout(sensor_ready, weight_sample);
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcsd_pkg::REG_DEADBAND: deadband_limit = cfg_data;
        lcsd_pkg::REG_STABILITY: stability_limit = cfg_data;
        lcsd_pkg::REG_CHANGE: change_limit = cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : check_readouts
    readout_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("Unexpected readout at cycle %0d: stable=%0b weight=%0d report=%0b",
                   cycle_count, stable, stable_weight, report);
      end else begin
        want = expected_readouts.pop_front();
        if (stable !== want.is_stable || stable_weight !== want.weight ||
            report !== want.send) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("Mismatch at cycle %0d: expected %0b/%0d/%0b, got %0b/%0d/%0b",
                     cycle_count, want.is_stable, want.weight, want.send,
                     stable, stable_weight, report);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= (rst || steady_mode) ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_reading(input logic rdy, input lcsd_pkg::sample_t w);
    while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sensor_ready <= rdy;
    weight_sample <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_readouts();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_readouts.size() != 0);
  endtask

  task automatic write_reg(input lcsd_pkg::cfg_idx_t idx, input lcsd_pkg::thr_t value);
    drain_readouts();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input lcsd_pkg::thr_t dead, input lcsd_pkg::thr_t stab,
                                input lcsd_pkg::thr_t chg);
    write_reg(lcsd_pkg::REG_DEADBAND, dead);
    write_reg(lcsd_pkg::REG_STABILITY, stab);
    write_reg(lcsd_pkg::REG_CHANGE, chg);
  endtask

  // Runs under the reset thresholds. The window first fills with readings
  // that the deadband zeroes, so the fill report comes with no weight change.
  task automatic test_fill_and_deadband();
    logic rdy_seq[23] = '{0, 0, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                          1, 1, 1, 1, 1, 1};
    int w_seq[23] = '{W_MAX, W_MIN, 5, -3, 1000, 9, -9, 2, 10, -10, 30, 50, 70,
                      90, 110, 130, 159, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX};
    for (int i = 0; i < 23; i++) send_reading(rdy_seq[i], lcsd_pkg::sample_t'(w_seq[i]));
  endtask

  task automatic test_register_writes();
    write_reg(REG_UNUSED, '0);
    for (int i = 0; i < 3; i++) send_reading(1'b1, lcsd_pkg::sample_t'(5));
    set_thresholds(THR_MAX, THR_MAX, THR_MAX);
    send_reading(1'b1, lcsd_pkg::sample_t'(W_MAX));
    send_reading(1'b1, lcsd_pkg::sample_t'(W_MIN));
    send_reading(1'b1, lcsd_pkg::sample_t'(W_MAX - 1));
    send_reading(1'b1, lcsd_pkg::sample_t'(0));
    set_thresholds('0, '0, '0);
    send_reading(1'b1, lcsd_pkg::sample_t'(-1));
    send_reading(1'b1, lcsd_pkg::sample_t'(-1));
  endtask

  // Most readings come in runs around a base weight with jitter inside the
  // stability threshold, so stable windows and reports occur often.
  task automatic test_random_traffic(input int n_items, input bit with_pause);
    int base;
    int run_left;
    int amp;
    int w;
    int roll;
    logic rdy;
    base = 0;
    run_left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (with_pause && k == n_items / 2) drain_readouts();
      if (run_left == 0) begin
        run_left = $urandom_range(12, 3);
        case ($urandom_range(3))
          0: base = int'(lcsd_pkg::sample_t'($urandom));
          1: base = int'($urandom_range(400)) - 200;
          2: begin
            base = int'(deadband_limit) + int'($urandom_range(4)) - 2;
            if ($urandom_range(1) == 1) base = -base;
          end
          default: base = -int'($urandom_range(5000));
        endcase
      end
      run_left--;
      amp = (int'(stability_limit) > 1000) ? 1000 : int'(stability_limit);
      if ($urandom_range(9) == 0) amp = 2 * amp + 4;
      roll = $urandom_range(99);
      rdy = (roll >= 8);
      if (roll < 13) w = int'(lcsd_pkg::sample_t'($urandom));
      else w = clamp_weight(base + int'($urandom_range(amp)) - amp / 2);
      send_reading(rdy, lcsd_pkg::sample_t'(w));
    end
  endtask

  task automatic test_threshold_phases();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_thresholds(lcsd_pkg::thr_t'($urandom_range(50)),
                          lcsd_pkg::thr_t'($urandom_range(100)),
                          lcsd_pkg::thr_t'($urandom_range(300)));
        1: set_thresholds('0, '0, '0);
        2: set_thresholds(THR_MAX, THR_MAX, THR_MAX);
        3: set_thresholds('0, THR_MAX, '0);
        4: set_thresholds(lcsd_pkg::DEADBAND_RESET, lcsd_pkg::STABILITY_RESET,
                          lcsd_pkg::CHANGE_RESET);
        default: set_thresholds(lcsd_pkg::thr_t'($urandom_range(100)),
                                lcsd_pkg::thr_t'($urandom), lcsd_pkg::thr_t'($urandom));
      endcase
      if (p == 0) begin
        steady_mode = 1'b1;
        test_random_traffic(150, 1'b0);
        steady_mode = 1'b0;
      end
      test_random_traffic(180, p == 4);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_fill_and_deadband();
    test_register_writes();
    test_threshold_phases();
    drain_readouts();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== load_cell_stability_detector.f =====
+incdir+hdl
hdl/lcsd_pkg.sv
hdl/lcsd_cell.sv
hdl/load_cell_stability_detector.sv
tb/load_cell_stability_detector_test.sv
